// ===== design/dvrt_pkg.sv =====
`timescale 1ns / 1ps
package dvrt_pkg;

  // field widths
  localparam int ADDR_W = 32;
  localparam int COST_W = 16;
  localparam int KIND_W = 3;

  // default table geometry
  localparam int MAX_DESTS_DEF = 16;
  localparam int MAX_HOPS_DEF  = 8;

  // result buffer: at most RES_MAX results per input item
  localparam int RES_MAX = 16;
  localparam int RES_AW  = $clog2(RES_MAX);
  localparam int RES_CW  = $clog2(RES_MAX + 1);

  // configuration register indexes
  localparam logic REG_OWN_ADDR = 1'b0;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_SENT   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_DONE    = 3'd0,
    K_INSTALL = 3'd1,
    K_DELETE  = 3'd2,
    K_LOOKUP  = 3'd3,
    K_FULL    = 3'd4
  } kind_t;

  // one result as stored in the result buffer
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
    logic [COST_W-1:0] cost;
    logic              found;
  } res_t;

  // sequencer to result buffer
  typedef struct packed {
    logic push;
    res_t res;
    logic start;
    logic flag;
  } q_ctrl_t;

  // result buffer to sequencer
  typedef struct packed {
    logic busy;
  } q_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FD_RD,
    ST_FD_CMP,
    ST_CNT_W,
    ST_SC_RD,
    ST_SC_CMP,
    ST_SC_END,
    ST_RM_HDR,
    ST_RM_HDR_W,
    ST_C_RD,
    ST_C_LD,
    ST_C_TST,
    ST_C_CP,
    ST_RM_END,
    ST_MV_HDR_W,
    ST_MV_RD,
    ST_MV_WR,
    ST_FIN,
    ST_DRN
  } state_t;

  typedef enum logic [2:0] {
    PH_UP_OLD,
    PH_UP_NEW,
    PH_RM_OLD,
    PH_RM_NEW,
    PH_LK
  } phase_t;

  typedef enum logic [1:0] {
    Q_FILL,
    Q_RD,
    Q_LD
  } qstate_t;

endpackage

// ===== design/dvrt_if.sv =====
`timescale 1ns / 1ps

// request channel
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] dest_addr;
  logic [31:0] via_addr;
  logic [15:0] route_cost;

  modport source (output valid, op, dest_addr, via_addr, route_cost, input ready);
  modport sink   (input valid, op, dest_addr, via_addr, route_cost, output ready);
endinterface

// result channel
interface dvrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] out_dest;
  logic [31:0] best_hop;
  logic [15:0] best_cost;
  logic        found;
  logic        vector_changed;
  logic        last;

  modport source (output valid, kind, out_dest, best_hop, best_cost, found, vector_changed,
                  last, input ready);
  modport sink   (input valid, kind, out_dest, best_hop, best_cost, found, vector_changed,
                  last, output ready);
endinterface

// ===== design/dvrt_ram.sv =====
`timescale 1ns / 1ps
module dvrt_ram #(
  parameter int W  = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dvrt_cfg.sv =====
`timescale 1ns / 1ps
module dvrt_cfg
  import dvrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] own_address
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (wr && paddr[2] == REG_OWN_ADDR) begin
      own_address <= pwdata;
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_OWN_ADDR) ? own_address : 32'd0;

endmodule

// ===== design/dvrt_resq.sv =====
`timescale 1ns / 1ps
module dvrt_resq
  import dvrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctl,
  output q_stat_t stat,
  dvrt_out_if.source out_ch
);

  res_t              mem [RES_MAX];
  res_t              rdata;
  logic [RES_CW-1:0] wcnt;
  logic [RES_CW-1:0] k;
  logic              flag_r;
  qstate_t           qst;
  logic              oload;
  logic              olast;

  assign stat.busy = (qst != Q_FILL);
  assign olast     = (k + RES_CW'(1)) == wcnt;
  assign oload     = (qst == Q_LD) && (!out_ch.valid || out_ch.ready);

  // buffer storage, registered read
  always_ff @(posedge clk) begin
    if (ctl.push && wcnt < RES_CW'(RES_MAX)) begin
      mem[wcnt[RES_AW-1:0]] <= ctl.res;
    end
    rdata <= mem[k[RES_AW-1:0]];
  end

  // fill count and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      qst  <= Q_FILL;
      wcnt <= '0;
      k    <= '0;
    end else begin
      case (qst)
        Q_FILL: begin
          if (ctl.push && wcnt < RES_CW'(RES_MAX)) begin
            wcnt <= wcnt + RES_CW'(1);
          end
          if (ctl.start) begin
            k   <= '0;
            qst <= Q_RD;
          end
        end
        Q_RD: qst <= Q_LD;
        Q_LD: begin
          if (oload) begin
            if (olast) begin
              wcnt <= '0;
              qst  <= Q_FILL;
            end else begin
              k   <= k + RES_CW'(1);
              qst <= Q_RD;
            end
          end
        end
        default: qst <= Q_FILL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      flag_r <= ctl.flag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (oload) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      out_ch.kind           <= rdata.kind;
      out_ch.out_dest       <= rdata.dest;
      out_ch.best_hop       <= rdata.hop;
      out_ch.best_cost      <= rdata.cost;
      out_ch.found          <= rdata.found;
      out_ch.vector_changed <= flag_r;
      out_ch.last           <= olast;
    end
  end

endmodule

// ===== design/dvrt_ctrl.sv =====
`timescale 1ns / 1ps
module dvrt_ctrl
  import dvrt_pkg::*;
#(
  parameter int MAX_DESTS = MAX_DESTS_DEF,
  parameter int MAX_HOPS  = MAX_HOPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] own_address,
  dvrt_in_if.sink     in_ch,
  input  q_stat_t     qs,
  output q_ctrl_t     qc
);

  localparam int DW  = $clog2(MAX_DESTS);
  localparam int HW  = $clog2(MAX_HOPS);
  localparam int UW  = $clog2(MAX_DESTS + 1);
  localparam int CW  = $clog2(MAX_HOPS + 1);
  localparam int HRW = ADDR_W + COST_W;
  localparam int TW  = ADDR_W + CW;

  state_t st, st_next;
  phase_t ph;

  // captured request
  op_t               op_r;
  logic [ADDR_W-1:0] dest_r;
  logic [ADDR_W-1:0] via_r;
  logic [COST_W-1:0] cost_r;

  // table state and working registers
  logic [UW-1:0]     used;
  logic              flag;
  logic              emitted;
  logic [UW-1:0]     idx;
  logic [DW-1:0]     cd;
  logic [DW-1:0]     lx;
  logic [ADDR_W-1:0] cdest;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     j;
  logic [CW-1:0]     r;
  logic [CW-1:0]     k;
  logic [CW-1:0]     ri;
  logic              hit;
  logic              bv, ov;
  logic [ADDR_W-1:0] bh, oh, cur_addr;
  logic [COST_W-1:0] bc, oc;
  logic [UW-1:0]     used_m1;
  logic              changed;

  // memory ports: header RAM holds {destination, hop count}
  logic              t_we;
  logic [DW-1:0]     t_waddr, t_raddr;
  logic [TW-1:0]     t_wdata, t_rdata;
  logic [ADDR_W-1:0] d_rdata;
  logic [CW-1:0]     c_rdata;
  logic              h_we;
  logic [DW+HW-1:0]  h_waddr, h_raddr;
  logic [HRW-1:0]    h_wdata, h_rdata;
  logic [ADDR_W-1:0] h_raddr_val;
  logic [COST_W-1:0] h_rcost;

  dvrt_ram #(.W(TW), .AW(DW)) u_hdr (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  dvrt_ram #(.W(HRW), .AW(DW + HW)) u_hop (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  assign d_rdata     = t_rdata[TW-1:CW];
  assign c_rdata     = t_rdata[CW-1:0];
  assign h_raddr_val = h_rdata[HRW-1:COST_W];
  assign h_rcost     = h_rdata[COST_W-1:0];
  assign used_m1     = used - UW'(1);
  assign changed     = !ov || (oc != bc) || (oh != bh);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // next state, memory ports, result pushes
  always_comb begin
    st_next     = st;
    in_ch.ready = 1'b0;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    qc = '0;
    qc.flag = flag;
    case (st)
      ST_IDLE: begin
        in_ch.ready = !qs.busy;
        if (in_ch.valid && !qs.busy) begin
          case (op_t'(in_ch.op))
            OP_UPDATE, OP_LOOKUP: st_next = ST_FD_RD;
            OP_REMOVE:            st_next = ST_RM_HDR;
            default:              st_next = ST_FIN;
          endcase
        end
      end
      // linear search of the destination table
      ST_FD_RD: begin
        t_raddr = idx[DW-1:0];
        if (idx < used) begin
          st_next = ST_FD_CMP;
        end else if (op_r == OP_LOOKUP) begin
          qc.push      = 1'b1;
          qc.res.kind  = K_LOOKUP;
          qc.res.dest  = dest_r;
          st_next      = ST_FIN;
        end else if (used >= UW'(MAX_DESTS)) begin
          qc.push      = 1'b1;
          qc.res.kind  = K_FULL;
          qc.res.dest  = dest_r;
          st_next      = ST_FIN;
        end else begin
          t_we    = 1'b1;
          t_waddr = used[DW-1:0];
          t_wdata = {dest_r, CW'(0)};
          st_next = ST_SC_RD;
        end
      end
      ST_FD_CMP: begin
        t_raddr = idx[DW-1:0];
        st_next = (d_rdata == dest_r) ? ST_CNT_W : ST_FD_RD;
      end
      ST_CNT_W: st_next = ST_SC_RD;
      // hop list scan: best route, and slot of via
      ST_SC_RD: begin
        h_raddr = {cd, j[HW-1:0]};
        st_next = (j < cnt) ? ST_SC_CMP : ST_SC_END;
      end
      ST_SC_CMP: st_next = ST_SC_RD;
      ST_SC_END: begin
        case (ph)
          PH_UP_OLD: begin
            if (!hit && cnt >= CW'(MAX_HOPS)) begin
              qc.push     = 1'b1;
              qc.res.kind = K_FULL;
              qc.res.dest = dest_r;
              st_next     = ST_FIN;
            end else begin
              h_we    = 1'b1;
              h_waddr = hit ? {cd, ri[HW-1:0]} : {cd, cnt[HW-1:0]};
              h_wdata = {via_r, cost_r};
              t_we    = !hit;
              t_waddr = cd;
              t_wdata = {dest_r, cnt + CW'(1)};
              st_next = ST_SC_RD;
            end
          end
          PH_UP_NEW: begin
            if (changed && dest_r != own_address) begin
              qc.push     = 1'b1;
              qc.res.kind = K_INSTALL;
              qc.res.dest = dest_r;
              qc.res.hop  = bh;
              qc.res.cost = bc;
            end
            st_next = ST_FIN;
          end
          PH_LK: begin
            qc.push      = 1'b1;
            qc.res.kind  = K_LOOKUP;
            qc.res.dest  = dest_r;
            qc.res.hop   = bv ? bh : '0;
            qc.res.cost  = bv ? bc : '0;
            qc.res.found = bv;
            st_next      = ST_FIN;
          end
          PH_RM_OLD: st_next = ST_C_RD;
          default: begin
            if (bv && changed && cdest != own_address) begin
              qc.push     = 1'b1;
              qc.res.kind = K_INSTALL;
              qc.res.dest = cdest;
              qc.res.hop  = bh;
              qc.res.cost = bc;
            end
            st_next = ST_RM_HDR;
          end
        endcase
      end
      // remove: per destination header
      ST_RM_HDR: begin
        t_raddr = idx[DW-1:0];
        st_next = (idx < used) ? ST_RM_HDR_W : ST_FIN;
      end
      ST_RM_HDR_W: st_next = ST_SC_RD;
      // swap-with-last compaction of the hop list
      ST_C_RD: begin
        h_raddr = {cd, r[HW-1:0]};
        st_next = (r < cnt) ? ST_C_LD : ST_RM_END;
      end
      ST_C_LD: st_next = ST_C_TST;
      ST_C_TST: begin
        h_raddr = {cd, cnt[HW-1:0] - HW'(1)};
        if (cur_addr == via_r && r != cnt - CW'(1)) begin
          st_next = ST_C_CP;
        end else begin
          st_next = ST_C_RD;
        end
      end
      ST_C_CP: begin
        h_we    = 1'b1;
        h_waddr = {cd, r[HW-1:0]};
        h_wdata = h_rdata;
        st_next = ST_C_TST;
      end
      ST_RM_END: begin
        t_we    = 1'b1;
        t_waddr = cd;
        t_wdata = {cdest, cnt};
        t_raddr = used_m1[DW-1:0];
        if (cnt == '0) begin
          if (cdest != own_address) begin
            qc.push     = 1'b1;
            qc.res.kind = K_DELETE;
            qc.res.dest = cdest;
          end
          st_next = (idx == used_m1) ? ST_RM_HDR : ST_MV_HDR_W;
        end else begin
          st_next = ST_SC_RD;
        end
      end
      // move the last destination into the emptied slot
      ST_MV_HDR_W: begin
        t_we    = 1'b1;
        t_waddr = cd;
        t_wdata = t_rdata;
        st_next = ST_MV_RD;
      end
      ST_MV_RD: begin
        h_raddr = {lx, k[HW-1:0]};
        st_next = (k < CW'(MAX_HOPS)) ? ST_MV_WR : ST_RM_HDR;
      end
      ST_MV_WR: begin
        h_we    = 1'b1;
        h_waddr = {cd, k[HW-1:0]};
        h_wdata = h_rdata;
        st_next = ST_MV_RD;
      end
      ST_FIN: begin
        if (!emitted) begin
          qc.push     = 1'b1;
          qc.res.kind = K_DONE;
          qc.res.dest = (op_r == OP_UPDATE) ? dest_r : '0;
        end
        st_next = ST_DRN;
      end
      ST_DRN: begin
        qc.start = 1'b1;
        st_next  = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      flag    <= 1'b0;
      emitted <= 1'b0;
    end else begin
      if (qc.push) begin
        emitted <= 1'b1;
      end
      case (st)
        ST_IDLE: begin
          if (in_ch.valid && !qs.busy) begin
            emitted <= 1'b0;
            if (op_t'(in_ch.op) == OP_SENT) begin
              flag <= 1'b0;
            end
          end
        end
        ST_FD_RD: begin
          if (idx >= used && op_r == OP_UPDATE && used < UW'(MAX_DESTS)) begin
            used <= used + UW'(1);
          end
        end
        ST_SC_END: begin
          if ((ph == PH_UP_NEW && changed) || (ph == PH_RM_NEW && bv && changed)) begin
            flag <= 1'b1;
          end
        end
        ST_RM_END: begin
          if (cnt == '0 && idx == used_m1) begin
            used <= used_m1;
          end
        end
        ST_MV_RD: begin
          if (k >= CW'(MAX_HOPS)) begin
            used <= used_m1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        op_r   <= op_t'(in_ch.op);
        dest_r <= in_ch.dest_addr;
        via_r  <= in_ch.via_addr;
        cost_r <= in_ch.route_cost;
        idx    <= '0;
      end
      ST_FD_RD: begin
        cd  <= used[DW-1:0];
        cnt <= '0;
        j   <= '0;
        bv  <= 1'b0;
        hit <= 1'b0;
        ph  <= PH_UP_OLD;
      end
      ST_FD_CMP: begin
        cd <= idx[DW-1:0];
        if (d_rdata != dest_r) begin
          idx <= idx + UW'(1);
        end
      end
      ST_CNT_W: begin
        cnt <= c_rdata;
        j   <= '0;
        bv  <= 1'b0;
        hit <= 1'b0;
        ph  <= (op_r == OP_LOOKUP) ? PH_LK : PH_UP_OLD;
      end
      ST_SC_CMP: begin
        if (!bv || h_rcost < bc) begin
          bv <= 1'b1;
          bh <= h_raddr_val;
          bc <= h_rcost;
        end
        if (!hit && h_raddr_val == via_r) begin
          hit <= 1'b1;
          ri  <= j;
        end
        j <= j + CW'(1);
      end
      ST_SC_END: begin
        ov <= bv;
        oh <= bh;
        oc <= bc;
        r  <= '0;
        j  <= '0;
        bv <= 1'b0;
        if (ph == PH_UP_OLD) begin
          if (!hit) begin
            cnt <= cnt + CW'(1);
          end
          ph <= PH_UP_NEW;
        end
        if (ph == PH_RM_NEW) begin
          idx <= idx + UW'(1);
        end
      end
      ST_RM_HDR_W: begin
        cd    <= idx[DW-1:0];
        cdest <= d_rdata;
        cnt   <= c_rdata;
        j     <= '0;
        bv    <= 1'b0;
        hit   <= 1'b0;
        ph    <= PH_RM_OLD;
      end
      ST_C_LD: begin
        cur_addr <= h_raddr_val;
      end
      ST_C_TST: begin
        if (cur_addr == via_r) begin
          cnt <= cnt - CW'(1);
        end else begin
          r <= r + CW'(1);
        end
      end
      ST_C_CP: begin
        cur_addr <= h_raddr_val;
      end
      ST_RM_END: begin
        lx  <= used_m1[DW-1:0];
        k   <= '0;
        j   <= '0;
        bv  <= 1'b0;
        ph  <= PH_RM_NEW;
      end
      ST_MV_WR: k <= k + CW'(1);
      default: ;
    endcase
  end

endmodule

// ===== design/distance_vector_route_table_unit.sv =====
`timescale 1ns / 1ps
// Distance-vector route table.
// Requests arrive on in_ch (op, dest_addr, via_addr, route_cost); each request
// yields one or more result beats on out_ch, the final one flagged by last.
// Every result beat carries the update flag as it stands after the request.
// own_address is written over the APB port (offset 0); the user is bound to
// write it only while the block is idle; the block does not enforce this.
// Destination headers (address and hop count) and hop lists sit in two RAMs;
// a sequencer walks them one entry at a time (read, compare, write back).
// One request is in flight at a time; the next is taken as soon as the last
// result beat sits in the output register, even if it has not been taken yet.
// A stalled receiver holds the output register and, in turn, the draining of
// the result buffer. Reset empties the table, clears the update flag and
// own_address; no clearing pass runs, the table is usable on the next cycle.
module distance_vector_route_table_unit
  import dvrt_pkg::*;
#(
  parameter int MAX_DESTS = MAX_DESTS_DEF,
  parameter int MAX_HOPS  = MAX_HOPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dvrt_in_if.sink     in_ch,
  dvrt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] own_address;
  q_ctrl_t     qc;
  q_stat_t     qs;

  dvrt_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .own_address(own_address)
  );

  dvrt_ctrl #(.MAX_DESTS(MAX_DESTS), .MAX_HOPS(MAX_HOPS)) u_ctrl (
    .clk(clk), .rst(rst), .own_address(own_address), .in_ch(in_ch), .qs(qs), .qc(qc)
  );

  dvrt_resq u_resq (
    .clk(clk), .rst(rst), .ctl(qc), .stat(qs), .out_ch(out_ch)
  );

endmodule
